// ===== rtl/core/dtsi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtsi_pkg
// Shared types and constants for the decimal text to scaled integer parser.
// ----------------------------------------------------------------------------
package dtsi_pkg;

  // Datapath widths
  localparam int unsigned ACC_W  = 60;  // magnitude, holds up to 18 digits
  localparam int unsigned VAL_W  = 61;  // signed scaled result
  localparam int unsigned CNT_W  = 5;   // digit counters and config fields
  localparam int unsigned CHAR_W = 8;

  // Digit counters stop here
  localparam logic [CNT_W-1:0] COUNT_SAT = 5'd19;

  // Largest power of ten applied by one padding stage
  localparam int unsigned PAD_STEP_MAX = 3;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Configuration register indexes
  localparam logic REG_TOTAL_DIGITS    = 1'b0;
  localparam logic REG_FRACTION_DIGITS = 1'b1;

  // A finished text on its way through the padding pipeline
  typedef struct packed {
    logic [ACC_W-1:0] mag;  // accumulated digits
    logic [CNT_W-1:0] pad;  // powers of ten still to apply
    logic             neg;  // minus sign seen
    logic             ok;   // text passed all checks
  } fin_t;

endpackage

// ===== rtl/core/dtsi_pad_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtsi_pad_stage
// One padding stage: multiplies the magnitude by up to 10^3 and lowers the
// remaining pad count; one register slot with a valid/ready handshake.
// ----------------------------------------------------------------------------
module dtsi_pad_stage
  import dtsi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  fin_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output fin_t out_data_o
);

  logic       valid_q;
  fin_t       data_q;
  fin_t       data_d;
  logic [1:0] step;

  // Number of decades applied here
  assign step = (in_data_i.pad > CNT_W'(PAD_STEP_MAX)) ? 2'(PAD_STEP_MAX)
                                                        : in_data_i.pad[1:0];

  always_comb begin
    data_d     = in_data_i;
    data_d.pad = in_data_i.pad - CNT_W'(step);
    unique case (step)
      2'd0: data_d.mag = in_data_i.mag;
      2'd1: data_d.mag = ACC_W'(in_data_i.mag * ACC_W'(10));
      2'd2: data_d.mag = ACC_W'(in_data_i.mag * ACC_W'(100));
      2'd3: data_d.mag = ACC_W'(in_data_i.mag * ACC_W'(1000));
      default: data_d.mag = in_data_i.mag;
    endcase
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // Slot valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Slot payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== rtl/core/decimal_text_to_scaled_integer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_scaled_integer_top
// Parses a decimal number text, one character per transfer, into a signed
// integer scaled by ten to the configured fraction digits.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake            Payload
// s_axis    in   tvalid/tready        tdata[7:0] char_code, tuser has_char,
//                                     tlast last
// m_axis    out  tvalid/tready        tdata[60:0] scaled result, tuser valid_res
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data (5 bits)
//
// One character is taken every cycle while s_axis_tready is high. A text's
// result passes through the finished-text register, PAD_STEPS = ceil(MAX_DIGITS/3)
// padding stages each multiplying by up to 10^3, and the output register. Each
// stage is a register slot with its own ready, so a stalled output fills the
// slots before input stops. Reset clears the parse state and empties the
// pipeline; config goes to precision 18, scale 0.
// ----------------------------------------------------------------------------
module decimal_text_to_scaled_integer_top
  import dtsi_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 18
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // character stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [7:0]             s_axis_tdata_i,   // [7:0] char_code
  input  logic                   s_axis_tuser_i,   // [0] has_char
  input  logic                   s_axis_tlast_i,
  // result stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [63:0]            m_axis_tdata_o,   // [60:0] scaled result
  output logic                   m_axis_tuser_o,   // [0] valid_res
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic [CNT_W-1:0]       cfg_data_i
);

  localparam int unsigned PAD_STEPS = (MAX_DIGITS + PAD_STEP_MAX - 1) / PAD_STEP_MAX;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] total_q, frac_cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= 5'd18;
      frac_cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TOTAL_DIGITS:    total_q    <= cfg_data_i;
        REG_FRACTION_DIGITS: frac_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Parse state
  // --------------------------------------------------------------------------
  logic [ACC_W-1:0] acc_q, acc_d;
  logic             minus_q, minus_d;
  logic             point_q, point_d;
  logic             first_q, first_d;
  logic             body_q, body_d;
  logic [CNT_W-1:0] whole_q, whole_d;
  logic [CNT_W-1:0] fcnt_q, fcnt_d;
  logic             bad_q, bad_d;

  logic             s_xfer;
  logic [7:0]       ch;
  logic             is_digit;
  logic [3:0]       dig;
  logic             take;

  // padding pipeline handshake
  logic             pv   [PAD_STEPS+1];
  logic             pr   [PAD_STEPS+1];
  fin_t             pd   [PAD_STEPS+1];
  fin_t             fin_d;

  assign ch       = s_axis_tdata_i;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dig      = 4'(ch - CH_ZERO);
  assign s_xfer   = s_axis_tvalid_i && s_axis_tready_o;

  // Character step
  always_comb begin
    acc_d   = acc_q;
    minus_d = minus_q;
    point_d = point_q;
    first_d = first_q;
    body_d  = body_q;
    whole_d = whole_q;
    fcnt_d  = fcnt_q;
    bad_d   = bad_q;
    take    = 1'b0;
    if (s_axis_tuser_i) begin
      if (!first_q && (ch == CH_MINUS)) begin
        minus_d = 1'b1;
        first_d = 1'b1;
      end else begin
        first_d = 1'b1;
        body_d  = 1'b1;
        if (ch == CH_POINT) begin
          if (point_q) bad_d = 1'b1;
          point_d = 1'b1;
        end else if (is_digit) begin
          if (point_q) begin
            take = 1'b1;
            if (fcnt_q < COUNT_SAT) fcnt_d = fcnt_q + 1'b1;
          end else if ((whole_q != '0) || (dig != 4'd0)) begin
            take = 1'b1;
            if (whole_q < COUNT_SAT) whole_d = whole_q + 1'b1;
          end
          // digits past the MAX_DIGITS limit are not kept
          if (take && (({1'b0, whole_d} + {1'b0, fcnt_d}) <= {1'b0, MAX_CNT})) begin
            acc_d = (acc_q << 3) + (acc_q << 1) + ACC_W'(dig);
          end
        end else begin
          bad_d = 1'b1;
        end
      end
    end
  end

  // End-of-text checks
  logic [CNT_W-1:0] prec;
  logic [CNT_W-1:0] scale;
  logic [CNT_W:0]   digits_sum;
  logic [CNT_W:0]   whole_scale;

  assign prec        = (total_q > MAX_CNT) ? MAX_CNT : total_q;
  assign scale       = frac_cfg_q;
  assign digits_sum  = {1'b0, whole_d} + {1'b0, fcnt_d};
  assign whole_scale = {1'b0, whole_d} + {1'b0, scale};

  always_comb begin
    fin_d.mag = acc_d;
    fin_d.pad = scale - fcnt_d;
    fin_d.neg = minus_d;
    fin_d.ok  = 1'b1;
    priority if (!first_d || !body_d || bad_d) begin
      fin_d.ok = 1'b0;
    end else if (fcnt_d > scale) begin
      fin_d.ok = 1'b0;
    end else if (digits_sum > {1'b0, prec}) begin
      fin_d.ok = 1'b0;
    end else if ((scale <= prec) && (whole_d > (prec - scale))) begin
      fin_d.ok = 1'b0;
    end else if (whole_scale > {1'b0, MAX_CNT}) begin
      fin_d.ok = 1'b0;
    end
  end

  // Parse registers: cleared after the last character of a text
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minus_q <= 1'b0;
      point_q <= 1'b0;
      first_q <= 1'b0;
      body_q  <= 1'b0;
      whole_q <= '0;
      fcnt_q  <= '0;
      bad_q   <= 1'b0;
      acc_q   <= '0;
    end else if (s_xfer) begin
      if (s_axis_tlast_i) begin
        minus_q <= 1'b0;
        point_q <= 1'b0;
        first_q <= 1'b0;
        body_q  <= 1'b0;
        whole_q <= '0;
        fcnt_q  <= '0;
        bad_q   <= 1'b0;
        acc_q   <= '0;
      end else begin
        minus_q <= minus_d;
        point_q <= point_d;
        first_q <= first_d;
        body_q  <= body_d;
        whole_q <= whole_d;
        fcnt_q  <= fcnt_d;
        bad_q   <= bad_d;
        acc_q   <= acc_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Finished-text register (head of the padding pipeline)
  // --------------------------------------------------------------------------
  logic fin_valid_q;
  fin_t fin_q;
  logic pr_next0;

  assign pr[0]           = !fin_valid_q || pr_next0;
  assign s_axis_tready_o = pr[0];
  assign pv[0]           = fin_valid_q;
  assign pd[0]           = fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (pr[0]) begin
      fin_valid_q <= s_axis_tvalid_i && s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer && s_axis_tlast_i) begin
      fin_q <= fin_d;
    end
  end

  // --------------------------------------------------------------------------
  // Padding stages
  // --------------------------------------------------------------------------
  logic ready_in [PAD_STEPS];

  for (genvar i = 0; i < PAD_STEPS; i++) begin : g_pad
    dtsi_pad_stage u_pad (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (pv[i]),
      .in_ready_o  (ready_in[i]),
      .in_data_i   (pd[i]),
      .out_valid_o (pv[i+1]),
      .out_ready_i (pr[i+1]),
      .out_data_o  (pd[i+1])
    );
    if (i > 0) begin : g_rdy
      assign pr[i] = ready_in[i];
    end
  end

  assign pr_next0 = ready_in[0];

  // --------------------------------------------------------------------------
  // Output register: sign and invalid handling
  // --------------------------------------------------------------------------
  logic             out_valid_q;
  logic [VAL_W-1:0] out_val_q, out_val_d;
  logic             out_ok_q;
  logic [VAL_W-1:0] mag_ext;

  assign pr[PAD_STEPS] = !out_valid_q || m_axis_tready_i;
  assign mag_ext       = {1'b0, pd[PAD_STEPS].mag};

  always_comb begin
    if (!pd[PAD_STEPS].ok) begin
      out_val_d = '0;
    end else if (pd[PAD_STEPS].neg) begin
      out_val_d = VAL_W'(~mag_ext + 1'b1);
    end else begin
      out_val_d = mag_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pr[PAD_STEPS]) begin
      out_valid_q <= pv[PAD_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pr[PAD_STEPS] && pv[PAD_STEPS]) begin
      out_val_q <= out_val_d;
      out_ok_q  <= pd[PAD_STEPS].ok;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_val_q};
  assign m_axis_tuser_o  = out_ok_q;

endmodule

// ===== tb/decimal_text_to_scaled_integer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_scaled_integer_checker
// Watches the character, result and configuration channels of the parser. It
// rebuilds each number from the accepted characters under the current
// precision and scale, queues the scaled value it predicts, and compares every
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module decimal_text_to_scaled_integer_checker
  import dtsi_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic [7:0]        s_axis_tdata_i,   // [7:0] char_code
  input  logic              s_axis_tuser_i,   // [0] has_char
  input  logic              s_axis_tlast_i,
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic [63:0]       m_axis_tdata_i,   // [60:0] scaled result
  input  logic              m_axis_tuser_i,   // [0] valid_res
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic              cfg_index_i,
  input  logic [CNT_W-1:0]  cfg_data_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       outstanding_o
);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             ok;
  } number_t;

  number_t predicted_numbers[$];
  int unsigned mismatches;

  // Configuration copy
  logic [CNT_W-1:0] precision;
  logic [CNT_W-1:0] scale;

  // Parse state of the number in flight
  logic [ACC_W-1:0] digits_acc;
  logic             neg_seen;
  logic             dot_seen;
  logic             started;
  logic             body_seen;
  logic [CNT_W-1:0] whole_cnt;
  logic [CNT_W-1:0] frac_cnt;
  logic             malformed;

  task automatic clear_number();
    digits_acc = '0;
    neg_seen   = 1'b0;
    dot_seen   = 1'b0;
    started    = 1'b0;
    body_seen  = 1'b0;
    whole_cnt  = '0;
    frac_cnt   = '0;
    malformed  = 1'b0;
  endtask

  task automatic take_digit(input int d);
    if (dot_seen) begin
      if (frac_cnt < COUNT_SAT) frac_cnt++;
    end else if (whole_cnt != 0 || d != 0) begin
      if (whole_cnt < COUNT_SAT) whole_cnt++;
    end else begin
      return;  // leading zero of the whole part
    end
    // digits past the limit are dropped, the number fails anyway
    if (int'(whole_cnt) + int'(frac_cnt) <= int'(MAX_DIGITS))
      digits_acc = digits_acc * 10 + ACC_W'(d);
  endtask

  task automatic take_char(input logic [7:0] c);
    if (!started && c == CH_MINUS) begin
      neg_seen = 1'b1;
      started  = 1'b1;
      return;
    end
    started   = 1'b1;
    body_seen = 1'b1;
    if (c == CH_POINT) begin
      if (dot_seen) malformed = 1'b1;
      dot_seen = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      take_digit(int'(c - CH_ZERO));
    end else begin
      malformed = 1'b1;
    end
  endtask

  // Range checks and padding of the finished number
  function automatic number_t close_number();
    number_t res;
    int p;
    int s;
    int w;
    int f;
    logic [VAL_W-1:0] v;
    p = (int'(precision) > int'(MAX_DIGITS)) ? int'(MAX_DIGITS) : int'(precision);
    s = int'(scale);
    w = int'(whole_cnt);
    f = int'(frac_cnt);
    res.ok = 1'b1;
    if (!started || !body_seen || malformed) res.ok = 1'b0;
    else if (f > s) res.ok = 1'b0;
    else if (w + f > p) res.ok = 1'b0;
    else if (s <= p && w > p - s) res.ok = 1'b0;
    else if (w + s > int'(MAX_DIGITS)) res.ok = 1'b0;
    res.value = '0;
    if (res.ok) begin
      v = VAL_W'(digits_acc);
      for (int i = f; i < s; i++) v = v * 10;
      if (neg_seen) v = -v;
      res.value = v;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    number_t got;
    number_t want;
    if (!rst_ni) begin
      predicted_numbers.delete();
      mismatches = 0;
      precision  = 5'd18;
      scale      = 5'd0;
      clear_number();
    end else begin
      // result side first: a result never stems from an input of the same edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.value = m_axis_tdata_i[VAL_W-1:0];
        got.ok    = m_axis_tuser_i;
        if (predicted_numbers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none pending: value %0d valid %0b",
                     $realtime, $signed(got.value), got.ok);
        end else begin
          want = predicted_numbers.pop_front();
          if (got.value !== want.value || got.ok !== want.ok) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected value %0d valid %0b, got value %0d valid %0b",
                       $realtime, $signed(want.value), want.ok,
                       $signed(got.value), got.ok);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_TOTAL_DIGITS:    precision = cfg_data_i;
          REG_FRACTION_DIGITS: scale     = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i) take_char(s_axis_tdata_i);
        if (s_axis_tlast_i) begin
          predicted_numbers = {predicted_numbers, close_number()};
          clear_number();
        end
      end
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= predicted_numbers.size();
  end

endmodule

// ===== tb/decimal_text_to_scaled_integer_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_scaled_integer_top_test
// Feeds number texts into the parser under a range of precision and scale
// settings: a few hand-picked texts, then random well-formed and broken ones,
// with random gaps on both sides and one long output stall. The checker
// predicts and compares; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module decimal_text_to_scaled_integer_top_test;
  import dtsi_pkg::*;

  localparam int unsigned MAX_DIGITS    = 18;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          SETTLE_CYCLES = 24;   // pipeline depth plus margin
  localparam int          HOLD_CYCLES   = 400;
  localparam int          HOLD_AT_ITEM  = 120;
  localparam int          PHASE_ITEMS   = 100;
  localparam logic [7:0]  CH_LETTER_A   = 8'h61;

  typedef logic [7:0] char_q_t[$];

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [7:0]       s_axis_tdata_i = '0;   // [7:0] char_code
  logic             s_axis_tuser_i = 1'b0; // [0] has_char
  logic             s_axis_tlast_i = 1'b0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [63:0]      m_axis_tdata_o;        // [60:0] scaled result
  logic             m_axis_tuser_o;        // [0] valid_res
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic             cfg_index_i = REG_TOTAL_DIGITS;
  logic [CNT_W-1:0] cfg_data_i = '0;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int          items_sent = 0;
  int          tx_idle_pct = 22;
  int          rx_idle_pct = 57;
  int          cycle_count = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;

  always #6 clk_i = ~clk_i;

  decimal_text_to_scaled_integer_top #(
    .MAX_DIGITS(MAX_DIGITS)
  ) uut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .s_axis_tlast_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  decimal_text_to_scaled_integer_checker #(
    .MAX_DIGITS(MAX_DIGITS)
  ) checker_i (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_i  (s_axis_tready_o),
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .s_axis_tlast_i,
    .m_axis_tvalid_i  (m_axis_tvalid_o),
    .m_axis_tready_i,
    .m_axis_tdata_i   (m_axis_tdata_o),
    .m_axis_tuser_i   (m_axis_tuser_o),
    .cfg_valid_i,
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  // Timeout guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold that backs up the pipeline
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_left       <= 0;
      hold_done       <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
      m_axis_tready_i <= 1'b0;
      hold_left       <= HOLD_CYCLES;
      hold_done       <= 1'b1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // One character transfer, after a random number of idle cycles
  task automatic send_char(input logic has_char, input logic [7:0] code,
                           input logic is_last);
    if (items_sent < 270) begin
      tx_idle_pct = 22;
      rx_idle_pct = 57;
    end else if (items_sent < 540) begin
      tx_idle_pct = 57;
      rx_idle_pct = 22;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= code;
    s_axis_tuser_i  <= has_char;
    s_axis_tlast_i  <= is_last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (has_char || is_last) items_sent++;
  endtask

  // Sends a whole text; closes it with an empty item when asked or when empty
  task automatic send_text(input char_q_t text, input bit close_empty,
                           input bit sprinkle);
    bit end_here;
    for (int i = 0; i < text.size(); i++) begin
      if (sprinkle && $urandom_range(9) == 0)
        send_char(1'b0, 8'($urandom_range(255)), 1'b0);
      end_here = !close_empty && (i == text.size() - 1);
      send_char(1'b1, text[i], end_here);
    end
    if (close_empty || text.size() == 0)
      send_char(1'b0, 8'($urandom_range(255)), 1'b1);
  endtask

  function automatic char_q_t chars(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q = {q, s[i]};
    return q;
  endfunction

  // Mostly well-formed numbers sized around the current limits, some noise
  function automatic char_q_t make_text(input int prec, input int scl);
    char_q_t t;
    int pe;
    int nw;
    int nf;
    pe = (prec > MAX_DIGITS) ? MAX_DIGITS : prec;
    if ($urandom_range(99) < 80) begin
      if ($urandom_range(1)) t = {t, CH_MINUS};
      if ($urandom_range(4) == 0) repeat ($urandom_range(1, 3)) t = {t, CH_ZERO};
      nw = ($urandom_range(9) < 7) ? $urandom_range(0, ((pe > scl) ? pe - scl : 0) + 1)
                                   : $urandom_range(0, 21);
      repeat (nw) t = {t, 8'(CH_ZERO + $urandom_range(9))};
      if ($urandom_range(9) < 6) begin
        t = {t, CH_POINT};
        nf = ($urandom_range(9) < 7) ? $urandom_range(0, scl + 1) : $urandom_range(0, 21);
        repeat (nf) t = {t, 8'(CH_ZERO + $urandom_range(9))};
      end
      // an occasional stray byte
      if ($urandom_range(19) == 0)
        t.insert($urandom_range(0, t.size()), 8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(3))
          0:       t = {t, CH_MINUS};
          1:       t = {t, CH_POINT};
          2:       t = {t, 8'(CH_ZERO + $urandom_range(9))};
          default: t = {t, 8'($urandom_range(255))};
        endcase
      end
    end
    return t;
  endfunction

  // Stop offering, then wait until every predicted result has come out
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_format(input logic [CNT_W-1:0] prec, input logic [CNT_W-1:0] scl);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_TOTAL_DIGITS;
    cfg_data_i  <= prec;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= REG_FRACTION_DIGITS;
    cfg_data_i  <= scl;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [CNT_W-1:0] prec_plan[8];
    logic [CNT_W-1:0] scale_plan[8];
    char_q_t          none;
    int               goal;
    prec_plan  = '{5'd18, 5'd1, 5'd18, 5'd5, 5'd31, 5'd12, 5'd1, 5'd18};
    scale_plan = '{5'd0,  5'd0, 5'd18, 5'd10, 5'd3, 5'd6,  5'd1, 5'd9};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset format first, then scale 4
    send_text(chars("-12"), 1'b0, 1'b0);
    send_text(chars("1.5"), 1'b0, 1'b0);       // fraction beyond scale
    set_format(5'd18, 5'd4);
    send_text(none, 1'b1, 1'b0);               // empty text
    send_text(chars("-"), 1'b0, 1'b0);         // lone sign
    send_text(chars("-9.5"), 1'b0, 1'b0);
    send_text(chars("."), 1'b0, 1'b0);
    send_text(chars(".."), 1'b0, 1'b0);        // second point
    send_text(chars("5-"), 1'b0, 1'b0);        // late minus
    send_text('{CH_LETTER_A}, 1'b0, 1'b0);     // bad character
    send_text(chars("007"), 1'b0, 1'b0);       // leading zeros
    send_char(1'b1, 8'h37, 1'b0);              // text ended by an empty item,
    send_char(1'b0, 8'hFF, 1'b0);              // with an ignored item inside
    send_char(1'b0, 8'h00, 1'b1);
    send_char(1'b1, 8'hFF, 1'b1);
    send_char(1'b1, 8'h00, 1'b1);

    // Random texts under each format
    for (int ph = 0; ph < 8; ph++) begin
      set_format(prec_plan[ph], scale_plan[ph]);
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal)
        send_text(make_text(int'(prec_plan[ph]), int'(scale_plan[ph])),
                  ($urandom_range(9) == 0), ($urandom_range(3) == 0));
    end

    settle();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
